// File: rtl/core/svp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Types and constants shared by the version string parser modules.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LOW_V = 8'h76;
    localparam logic [7:0]  CHAR_UP_V  = 8'h56;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [19:0] FIELD_MAX  = 20'd65535;
    localparam logic [19:0] RADIX      = 20'd10;

    typedef enum logic [2:0] {
        CC_SPACE,
        CC_DIGIT,
        CC_VEE,
        CC_DOT,
        CC_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_MAJOR,
        PH_MINOR,
        PH_PATCH,
        PH_DOT,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic        present;
        logic        last;
        char_class_t cls;
        logic [3:0]  digit;
    } char_entry_t;

endpackage

// File: rtl/core/svp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_front
// Classifies each incoming character and hands it to the queue as one entry.
// ----------------------------------------------------------------------------
module svp_front (
    input  logic                 char_valid,
    output logic                 char_stall,
    input  logic [7:0]           char_code,
    input  logic                 char_present,
    input  logic                 is_last,
    output logic                 push_valid,
    input  logic                 queue_full,
    output svp_pkg::char_entry_t push_entry
);
    import svp_pkg::*;

    char_class_t cls;

    always_comb
    begin
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            cls = CC_DIGIT;
        end
        else if (char_code == CHAR_SPACE || (char_code >= CHAR_TAB && char_code <= CHAR_CR))
        begin
            cls = CC_SPACE;
        end
        else if (char_code == CHAR_LOW_V || char_code == CHAR_UP_V)
        begin
            cls = CC_VEE;
        end
        else if (char_code == CHAR_DOT)
        begin
            cls = CC_DOT;
        end
        else
        begin
            cls = CC_OTHER;
        end
    end

    always_comb
    begin
        push_entry.present = char_present;
        push_entry.last    = is_last;
        push_entry.cls     = cls;
        push_entry.digit   = char_code[3:0];
    end

    assign push_valid = char_valid;
    assign char_stall = queue_full;

endmodule

// File: rtl/core/svp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_queue
// Short first-in first-out queue of classified characters between the
// front and back parts.
// ----------------------------------------------------------------------------
module svp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  svp_pkg::char_entry_t push_entry,
    output logic                 full,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output svp_pkg::char_entry_t pop_entry
);
    import svp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    char_entry_t      slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/svp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_back
// Runs the version parsing state machine on classified characters and holds
// the finished result in an output register.
// ----------------------------------------------------------------------------
module svp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  svp_pkg::char_entry_t pop_entry,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 version_ok,
    output logic [15:0]          major_part,
    output logic [15:0]          minor_part,
    output logic [15:0]          patch_part
);
    import svp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic        seen_reg;
    logic        seen_next;
    logic [15:0] major_reg;
    logic [15:0] major_next;
    logic [15:0] minor_reg;
    logic [15:0] minor_next;
    logic        failed_reg;
    logic        failed_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        ok_reg;
    logic        ok_next;
    logic [15:0] out_major_reg;
    logic [15:0] out_major_next;
    logic [15:0] out_minor_reg;
    logic [15:0] out_minor_next;
    logic [15:0] out_patch_reg;
    logic [15:0] out_patch_next;
    logic        pop;
    logic        in_field;
    phase_t      field_phase;
    logic [19:0] acc_wide;
    logic        ok;

    assign pop_ready = !pop_entry.last || !out_valid_reg || !result_stall;
    assign pop       = pop_valid && pop_ready;
    assign acc_wide  = 20'(acc_reg) * RADIX + 20'(pop_entry.digit);

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && result_stall;
        ok_next        = ok_reg;
        out_major_next = out_major_reg;
        out_minor_next = out_minor_reg;
        out_patch_next = out_patch_reg;
        in_field       = 1'b0;
        field_phase    = phase_reg;
        ok             = 1'b0;

        if (pop && pop_entry.present && !failed_reg)
        begin
            unique case (phase_reg) inside
                PH_SPACE:
                begin
                    if (pop_entry.cls != CC_SPACE)
                    begin
                        phase_next = PH_MAJOR;
                        if (pop_entry.cls != CC_VEE)
                        begin
                            in_field    = 1'b1;
                            field_phase = PH_MAJOR;
                        end
                    end
                end
                PH_MAJOR, PH_MINOR, PH_PATCH:
                begin
                    in_field = 1'b1;
                end
                PH_DOT:
                begin
                    if (pop_entry.cls == CC_DIGIT)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                end
                default:
                begin
                end
            endcase

            if (in_field)
            begin
                if (pop_entry.cls == CC_DIGIT)
                begin
                    if (acc_wide > FIELD_MAX)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        acc_next  = acc_wide[15:0];
                        seen_next = 1'b1;
                    end
                end
                else if (!seen_reg)
                begin
                    failed_next = 1'b1;
                end
                else if (field_phase == PH_PATCH)
                begin
                    phase_next = (pop_entry.cls == CC_DOT) ? PH_DOT : PH_TAIL;
                end
                else if (pop_entry.cls != CC_DOT)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    if (field_phase == PH_MAJOR)
                    begin
                        major_next = acc_reg;
                        phase_next = PH_MINOR;
                    end
                    else
                    begin
                        minor_next = acc_reg;
                        phase_next = PH_PATCH;
                    end
                    acc_next  = '0;
                    seen_next = 1'b0;
                end
            end
        end

        if (pop && pop_entry.last)
        begin
            ok = !failed_next && ((phase_next == PH_PATCH && seen_next)
                 || phase_next == PH_DOT || phase_next == PH_TAIL);
            out_valid_next = 1'b1;
            ok_next        = ok;
            out_major_next = ok ? major_next : '0;
            out_minor_next = ok ? minor_next : '0;
            out_patch_next = ok ? acc_next : '0;
            phase_next     = PH_SPACE;
            acc_next       = '0;
            seen_next      = 1'b0;
            major_next     = '0;
            minor_next     = '0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg        <= ok_next;
        out_major_reg <= out_major_next;
        out_minor_reg <= out_minor_next;
        out_patch_reg <= out_patch_next;
    end

    assign result_valid = out_valid_reg;
    assign version_ok   = ok_reg;
    assign major_part   = out_major_reg;
    assign minor_part   = out_minor_reg;
    assign patch_part   = out_patch_reg;

endmodule

// File: rtl/core/semver_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semver_string_parser
// Parses a "major.minor.patch" version string, one character per beat.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock cycle while char_stall is low
// and gives one result beat for each beat flagged last, in order. A beat
// passes through the classifier into a queue of QUEUE_DEPTH entries and is
// then consumed by the parsing state machine; a last beat is registered in
// a queue slot and then in the output register before its result shows. The
// rate is set by the combinational multiply-by-ten update of the field value;
// a stalled result holds back only a last beat, and beats behind it wait.
module semver_string_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        char_present,
    input  logic        is_last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        version_ok,
    output logic [15:0] major_part,
    output logic [15:0] minor_part,
    output logic [15:0] patch_part
);
    import svp_pkg::*;

    char_entry_t push_entry;
    char_entry_t pop_entry;
    logic        push_valid;
    logic        queue_full;
    logic        pop_valid;
    logic        pop_ready;

    svp_front u_front (
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .char_present (char_present),
        .is_last      (is_last),
        .push_valid   (push_valid),
        .queue_full   (queue_full),
        .push_entry   (push_entry)
    );

    svp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    svp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .version_ok   (version_ok),
        .major_part   (major_part),
        .minor_part   (minor_part),
        .patch_part   (patch_part)
    );

endmodule

// File: test/semver_string_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semver_string_parser_test
// Self-checking testbench for the version string parser.
// ----------------------------------------------------------------------------
// Character beats are sent through the input handshake and every string is
// predicted in the testbench, parse phase by parse phase. Each result beat is
// compared field by field with the oldest predicted version. Directed strings
// cover whitespace, the optional prefix, field limits and tail handling.
// Random well-formed versions with mutations and raw byte noise follow, and
// a long result hold-off forces the input to stall. Both sides idle at random.
// ----------------------------------------------------------------------------
module semver_string_parser_test;

    import svp_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int NOISE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        logic        ok;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] patch;
    } version_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_code = 8'h00;
    logic        char_present = 1'b0;
    logic        is_last = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        version_ok;
    logic [15:0] major_part;
    logic [15:0] minor_part;
    logic [15:0] patch_part;

    version_t    pending_versions[$];
    phase_t      ph = PH_SPACE;
    int unsigned field_acc = 0;
    logic        field_seen = 1'b0;
    logic [15:0] major_kept = 16'd0;
    logic [15:0] minor_kept = 16'd0;
    logic        rejected = 1'b0;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_off = 1'b0;
    int stall_left = 0;
    int items_sent = 0;
    int input_stalls = 0;
    int strings_checked = 0;
    int strings_valid = 0;
    int mismatches = 0;
    int cycles = 0;

    semver_string_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .char_present (char_present),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .version_ok   (version_ok),
        .major_part   (major_part),
        .minor_part   (minor_part),
        .patch_part   (patch_part)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic predict_char(input logic [7:0] code, input logic present, input logic last);
        logic        blank;
        logic        digit;
        logic        skip;
        int unsigned nxt;
        version_t    want;
        blank = (code == CHAR_SPACE) || (code >= CHAR_TAB && code <= CHAR_CR);
        digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
        skip = 1'b0;
        if (present && !rejected)
        begin
            if (ph == PH_SPACE)
            begin
                if (blank)
                begin
                    skip = 1'b1;
                end
                else
                begin
                    ph = PH_MAJOR;
                    skip = (code == CHAR_LOW_V) || (code == CHAR_UP_V);
                end
            end
            if (!skip)
            begin
                case (ph) inside
                    PH_MAJOR, PH_MINOR, PH_PATCH:
                    begin
                        if (digit)
                        begin
                            nxt = field_acc * RADIX + (code - CHAR_ZERO);
                            if (nxt > FIELD_MAX)
                            begin
                                rejected = 1'b1;
                            end
                            else
                            begin
                                field_acc = nxt;
                                field_seen = 1'b1;
                            end
                        end
                        else if (!field_seen)
                        begin
                            rejected = 1'b1;
                        end
                        else if (ph == PH_PATCH)
                        begin
                            if (code == CHAR_DOT)
                                ph = PH_DOT;
                            else
                                ph = PH_TAIL;
                        end
                        else if (code != CHAR_DOT)
                        begin
                            rejected = 1'b1;
                        end
                        else
                        begin
                            if (ph == PH_MAJOR)
                            begin
                                major_kept = field_acc[15:0];
                                ph = PH_MINOR;
                            end
                            else
                            begin
                                minor_kept = field_acc[15:0];
                                ph = PH_PATCH;
                            end
                            field_acc = 0;
                            field_seen = 1'b0;
                        end
                    end
                    PH_DOT:
                    begin
                        if (digit)
                            rejected = 1'b1;
                        else
                            ph = PH_TAIL;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (last)
        begin
            want.ok = !rejected &&
                      ((ph == PH_PATCH && field_seen) || ph == PH_DOT || ph == PH_TAIL);
            want.major = want.ok ? major_kept : 16'd0;
            want.minor = want.ok ? minor_kept : 16'd0;
            want.patch = want.ok ? field_acc[15:0] : 16'd0;
            pending_versions.push_back(want);
            ph = PH_SPACE;
            field_acc = 0;
            field_seen = 1'b0;
            major_kept = 16'd0;
            minor_kept = 16'd0;
            rejected = 1'b0;
        end
    endtask

    task automatic send_char(input logic [7:0] code, input logic present, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code <= code;
        char_present <= present;
        is_last <= last;
        @(posedge clk);
        while (char_stall)
        begin
            input_stalls++;
            @(posedge clk);
        end
        if (present)
            items_sent++;
        predict_char(code, present, last);
    endtask

    // Empty markers may be slipped in between characters or used to close the string.
    task automatic send_text(input text_t t, input bit markers, input bit end_marker);
        foreach (t[i])
        begin
            if (markers && $urandom_range(0, 15) == 0)
                send_char(8'($urandom), 1'b0, 1'b0);
            send_char(t[i], 1'b1, !end_marker && i == t.size() - 1);
        end
        if (end_marker || t.size() == 0)
            send_char(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic text_t to_text(input string s);
        text_t t;
        foreach (s[i])
            t.push_back(s[i]);
        return t;
    endfunction

    function automatic string field_text();
        int unsigned v;
        string       s;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 65535;
            2: v = $urandom_range(65536, 999999);
            3: v = $urandom_range(0, 9);
            4, 5: v = $urandom_range(0, 999);
            default: v = $urandom_range(0, 65535);
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"00", s};
        if ($urandom_range(0, 19) == 0)
            s = "";
        return s;
    endfunction

    function automatic text_t random_version();
        text_t t;
        string s;
        int    pos;
        repeat ($urandom_range(0, 2))
            t.push_back($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
        case ($urandom_range(0, 3))
            0: s = "v";
            1: s = "V";
            default: s = "";
        endcase
        s = {s, field_text(), ".", field_text(), ".", field_text()};
        case ($urandom_range(0, 9))
            0: s = {s, "."};
            1: s = {s, ".", $sformatf("%0d", $urandom_range(0, 9))};
            2: s = {s, ".x"};
            3: s = {s, "-rc.", $sformatf("%0d", $urandom_range(0, 99))};
            4: s = {s, "+build.7"};
            5: s = {s, " "};
            default: s = s;
        endcase
        t = {t, to_text(s)};
        if ($urandom_range(0, 4) == 0 && t.size() > 0)
        begin
            pos = $urandom_range(0, t.size() - 1);
            case ($urandom_range(0, 2))
                0: t[pos] = 8'($urandom_range(0, 255));
                1: t.delete(pos);
                default: t.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
        return t;
    endfunction

    task automatic note_mismatch(input string what, input version_t want, input version_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch, %s: expected ok=%0b %0d.%0d.%0d, got ok=%0b %0d.%0d.%0d",
                     what, want.ok, want.major, want.minor, want.patch,
                     got.ok, got.major, got.minor, got.patch);
    endtask

    always @(posedge clk)
    begin
        version_t want;
        version_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {version_ok, major_part, minor_part, patch_part};
            strings_checked++;
            if (got.ok === 1'b1)
                strings_valid++;
            if (pending_versions.size() == 0)
            begin
                note_mismatch("result with no string pending", '0, got);
            end
            else
            begin
                want = pending_versions.pop_front();
                if (got.ok !== want.ok || got.major !== want.major ||
                    got.minor !== want.minor || got.patch !== want.patch)
                    note_mismatch($sformatf("string %0d", strings_checked), want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            stall_left = recv_idle ? $urandom_range(0, 10) : 0;
        if (hold_off || stall_left > 0)
        begin
            result_stall <= 1'b1;
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    task automatic test_directed();
        text_t t;
        send_text(to_text("1.2.3"), 1'b0, 1'b0);
        send_text(to_text("v0.0.0"), 1'b0, 1'b0);
        send_text(to_text("V65535.65535.65535"), 1'b0, 1'b0);
        t = {to_text(" \t\n\v\f"), CHAR_CR, to_text("10.20.30")};
        send_text(t, 1'b0, 1'b0);
        t = {8'h08, to_text("1.2.3")};
        send_text(t, 1'b0, 1'b0);
        t = {8'h0E, to_text("1.2.3")};
        send_text(t, 1'b0, 1'b0);
        send_text(to_text("65536.0.0"), 1'b0, 1'b0);
        send_text(to_text("1.2.65536"), 1'b0, 1'b0);
        send_text(to_text("000000000012.0.7"), 1'b0, 1'b0);
        send_text(to_text("1..3"), 1'b0, 1'b0);
        send_text(to_text(".1.2"), 1'b0, 1'b0);
        send_text(to_text("1.2"), 1'b0, 1'b0);
        send_text(to_text("1.2."), 1'b0, 1'b0);
        send_text(to_text("1-2.3"), 1'b0, 1'b0);
        send_text(to_text("1.2.3.4"), 1'b0, 1'b0);
        send_text(to_text("1.2.3."), 1'b0, 1'b0);
        send_text(to_text("1.2.3.x"), 1'b0, 1'b0);
        send_text(to_text("1.2.3-rc.1 "), 1'b0, 1'b0);
        send_text(to_text("vv1.2.3"), 1'b0, 1'b0);
        send_text(to_text("v 1.2.3"), 1'b0, 1'b0);
        t = to_text("4.5.6");
        t.push_back(8'h00);
        t.push_back(8'hFF);
        send_text(t, 1'b0, 1'b0);
        send_char(8'hFF, 1'b0, 1'b1);
        t = to_text("3.4");
        foreach (t[i])
            send_char(t[i], 1'b1, 1'b0);
        send_char(8'hA5, 1'b0, 1'b0);
        send_text(to_text(".5"), 1'b0, 1'b1);
    endtask

    task automatic test_random_versions();
        int first;
        int strings;
        first = items_sent;
        strings = 0;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            if (strings % 40 == 0)
            begin
                send_idle = $urandom_range(0, 2) != 0;
                recv_idle <= $urandom_range(0, 2) != 0;
            end
            send_text(random_version(), 1'b1, $urandom_range(0, 15) == 0);
            strings++;
        end
    endtask

    task automatic test_noise();
        text_t t;
        int    first;
        string charset;
        charset = "0123456789.vV ";
        send_idle = 1'b1;
        recv_idle <= 1'b1;
        first = items_sent;
        while (items_sent - first < NOISE_ITEMS)
        begin
            t.delete();
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 1))
                    t.push_back(8'($urandom_range(0, 255)));
                else
                    t.push_back(charset[$urandom_range(0, 13)]);
            end
            send_text(t, 1'b1, $urandom_range(0, 7) == 0);
        end
    endtask

    // The receiver holds off while the sender keeps offering short strings back to back.
    task automatic test_backpressure();
        send_idle = 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int k = 0; k < 30; k++)
            send_text(to_text($sformatf("%0d.%0d.%0d", k, k + 1, k * 7)), 1'b0, 1'b0);
        send_idle = 1'b1;
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("semver_string_parser_test: errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_versions();
        test_noise();
        test_backpressure();
        char_valid <= 1'b0;
        while (pending_versions.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        $display("Checked %0d strings from %0d characters: %0d valid, %0d rejected, %0d mismatches.",
                 strings_checked, items_sent, strings_valid, strings_checked - strings_valid,
                 mismatches);
        $display("Input stalled on %0d cycles, with a %0d-cycle result hold-off; %0d cycles run.",
                 input_stalls, HOLD_CYCLES, cycles);
        if (mismatches == 0)
            $display("semver_string_parser_test: clean");
        else
            $display("semver_string_parser_test: errors");
        $finish;
    end

endmodule
